[sv/servo_pulse_to_sbus_frame_encoder_core_defines.svh]
// ----------------------------------------------------------------------------
// SBUS frame encoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_TO_SBUS_FRAME_ENCODER_CORE_DEFINES_SVH
`define SERVO_PULSE_TO_SBUS_FRAME_ENCODER_CORE_DEFINES_SVH

// Check that a property holds at every clock edge out of reset.
`define SBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sbus_enc_pkg.sv]
// ----------------------------------------------------------------------------
// SBUS frame encoder package
// Beat types and frame constants shared by the encoder.
// ----------------------------------------------------------------------------
package sbus_enc_pkg;

  // Input beat: one channel's pulse width
  typedef struct packed {
    logic [11:0] pulse_width;
    logic        signal_loss;
  } in_beat_t;

  // Output beat: one byte of the frame
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_beat_t;

  localparam logic [7:0]  HdrByte  = 8'h0F;
  localparam logic [7:0]  FtrByte  = 8'h00;
  localparam logic [7:0]  FlagLoss = 8'h04;
  localparam logic [7:0]  FlagNone = 8'h00;

  localparam logic [11:0] PwMin    = 12'd1000;
  localparam logic [11:0] PwMax    = 12'd2000;
  localparam logic [9:0]  PwSpan   = 10'd1000;

  localparam logic [10:0] SbMin    = 11'd173;
  localparam logic [10:0] SbMax    = 11'd1811;

  // floor(d * 1638 / 1000) == (d * RecipK) >> RecipShift for d in 0..1000
  localparam logic [20:0] RecipK     = 21'd1717568;
  localparam int          RecipShift = 20;

  localparam logic [3:0]  ChLast   = 4'd15;

endpackage

[sv/servo_pulse_to_sbus_frame_encoder_core.sv]
// ----------------------------------------------------------------------------
// SBUS frame encoder core
// Turns servo pulse widths for channels 0..15 into a 25-byte SBUS frame.
// ----------------------------------------------------------------------------
// One input beat carries the pulse width of the next channel, 0 through 15 in
// order. The width is clamped to 1000..2000 us and mapped to an 11-bit value
// 173 + floor((w - 1000) * 1638 / 1000), packed LSB first into the frame. Each
// input beat yields one to four output beats: the header 0x0F before channel
// 0, every data byte as soon as it fills, and after channel 15 a flag byte
// (bit 2 = signal_loss of that beat) and the footer 0x00 with frame_end set.
// The input side takes one beat per cycle, unless in_stall_o holds it off,
// into a three-register pipeline (clamp, multiply, pack) that feeds the output
// register. The byte burst of an item drains at one byte per cycle while
// out_stall_i is low; a new item enters the pack register only as the last
// byte of the previous burst leaves, so the input stalls while a burst drains.
// ----------------------------------------------------------------------------
`include "servo_pulse_to_sbus_frame_encoder_core_defines.svh"

module servo_pulse_to_sbus_frame_encoder_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sbus_enc_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sbus_enc_pkg::out_beat_t out_data_o
);

  import sbus_enc_pkg::*;

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  // Stage 0: clamped offset from 1000 us
  logic        s0_valid_q;
  logic [9:0]  s0_off_q;
  logic        s0_loss_q;
  // Stage 1: mapped 11-bit channel value
  logic        s1_valid_q;
  logic [10:0] s1_val_q;
  logic        s1_loss_q;
  // Packing state between items
  logic [3:0]  ch_q, ch_d;
  logic [6:0]  buf_q, buf_d;
  logic [2:0]  cnt_q, cnt_d;
  // Byte burst of one item
  logic        burst_valid_q;
  logic [7:0]  burst_q [4];
  logic [2:0]  burst_num_q;
  logic        burst_end_q;
  // Output register
  logic        out_valid_q;
  out_beat_t   out_q;

  // --------------------------------------------------------------------------
  // Flow control: each stage loads when it is empty or moves on this cycle
  // --------------------------------------------------------------------------
  logic out_load, burst_free, pack_load, s1_free, s1_load, s0_free, in_load;

  assign out_load   = burst_valid_q && (!out_valid_q || !out_stall_i);
  assign burst_free = !burst_valid_q || (out_load && (burst_num_q == 3'd1));
  assign pack_load  = s1_valid_q && burst_free;
  assign s1_free    = !s1_valid_q || pack_load;
  assign s1_load    = s0_valid_q && s1_free;
  assign s0_free    = !s0_valid_q || s1_load;
  assign in_load    = in_valid_i && s0_free;

  assign in_stall_o  = !s0_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Stage 0 input: clamp width and take the offset from the low end
  // --------------------------------------------------------------------------
  logic [11:0] pw_clamped;
  logic [11:0] pw_off;

  always_comb begin
    if (in_data_i.pulse_width < PwMin) begin
      pw_clamped = PwMin;
    end else if (in_data_i.pulse_width > PwMax) begin
      pw_clamped = PwMax;
    end else begin
      pw_clamped = in_data_i.pulse_width;
    end
    pw_off = pw_clamped - PwMin;
  end

  // --------------------------------------------------------------------------
  // Stage 1 input: scale by 1638/1000 through an exact reciprocal multiply
  // --------------------------------------------------------------------------
  logic [30:0] scaled;
  logic [10:0] sb_val;

  assign scaled = 31'(s0_off_q) * 31'(RecipK);
  assign sb_val = SbMin + scaled[RecipShift +: 11];

  // --------------------------------------------------------------------------
  // Pack: merge the value into the bit buffer and build the byte burst
  // --------------------------------------------------------------------------
  logic [17:0] merged;
  logic [4:0]  total;
  logic        two_bytes;
  logic [7:0]  pk_bytes [4];
  logic [2:0]  pk_num;

  always_comb begin
    merged    = 18'(buf_q) | (18'(s1_val_q) << cnt_q);
    total     = 5'(cnt_q) + 5'd11;
    two_bytes = total[4];

    for (int i = 0; i < 4; i++) begin
      pk_bytes[i] = FtrByte;
    end
    pk_num = 3'd0;

    // Header leads channel 0
    if (ch_q == 4'd0) begin
      pk_bytes[pk_num[1:0]] = HdrByte;
      pk_num = pk_num + 3'd1;
    end
    pk_bytes[pk_num[1:0]] = merged[7:0];
    pk_num = pk_num + 3'd1;
    if (two_bytes) begin
      pk_bytes[pk_num[1:0]] = merged[15:8];
      pk_num = pk_num + 3'd1;
    end
    // Flag and footer close the frame
    if (ch_q == ChLast) begin
      pk_bytes[pk_num[1:0]] = s1_loss_q ? FlagLoss : FlagNone;
      pk_num = pk_num + 3'd1;
      pk_bytes[pk_num[1:0]] = FtrByte;
      pk_num = pk_num + 3'd1;
    end

    // Residual bits; count is total-8 or total-16, both equal total[2:0]
    cnt_d = total[2:0];
    buf_d = two_bytes ? {5'd0, merged[17:16]} : merged[14:8];
    ch_d  = ch_q + 4'd1;
    if (ch_q == ChLast) begin
      cnt_d = 3'd0;
      buf_d = 7'd0;
      ch_d  = 4'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q    <= 1'b0;
      s1_valid_q    <= 1'b0;
      burst_valid_q <= 1'b0;
      burst_num_q   <= 3'd0;
      out_valid_q   <= 1'b0;
      ch_q          <= 4'd0;
      buf_q         <= 7'd0;
      cnt_q         <= 3'd0;
    end else begin
      if (s0_free) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_free) begin
        s1_valid_q <= s0_valid_q;
      end
      // Advance the packing state once per item
      if (pack_load) begin
        ch_q  <= ch_d;
        buf_q <= buf_d;
        cnt_q <= cnt_d;
      end
      // Load a fresh burst, or count down as bytes leave
      if (pack_load) begin
        burst_valid_q <= 1'b1;
        burst_num_q   <= pk_num;
      end else if (out_load) begin
        burst_valid_q <= (burst_num_q != 3'd1);
        burst_num_q   <= burst_num_q - 3'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s0_off_q  <= pw_off[9:0];
      s0_loss_q <= in_data_i.signal_loss;
    end
    if (s1_load) begin
      s1_val_q  <= sb_val;
      s1_loss_q <= s0_loss_q;
    end
    if (pack_load) begin
      burst_q     <= pk_bytes;
      burst_end_q <= (ch_q == ChLast);
    end else if (out_load) begin
      // Shift the next byte to the head
      for (int i = 0; i < 3; i++) begin
        burst_q[i] <= burst_q[i + 1];
      end
    end
    if (out_load) begin
      out_q.frame_byte <= burst_q[0];
      out_q.frame_end  <= burst_end_q && (burst_num_q == 3'd1);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SBE_ASSERT(a_burst_num,
              !burst_valid_q || ((burst_num_q != 3'd0) && (burst_num_q <= 3'd4)),
              "burst byte count out of range")
  `SBE_ASSERT(a_frame_align, (ch_q != 4'd0) || (cnt_q == 3'd0),
              "bit buffer not empty at frame start")
  `SBE_ASSERT(a_value_range,
              !s1_valid_q || ((s1_val_q >= SbMin) && (s1_val_q <= SbMax)),
              "mapped channel value out of range")
  `SBE_ASSERT_NEXT(a_wrap, pack_load && (ch_q == ChLast),
                   (ch_q == 4'd0) && (burst_num_q == 3'd4),
                   "frame did not close with four bytes")
  `SBE_ASSERT(a_end_footer,
              !(out_valid_q && out_q.frame_end) || (out_q.frame_byte == FtrByte),
              "frame end on a byte other than the footer")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SBUS frame encoder testbench
// Streams servo pulse widths into the encoder and checks every frame byte.
// ----------------------------------------------------------------------------
// A scoreboard model packs the clamped and scaled channel values into frame
// bytes as each input beat is accepted. A checker process compares every
// output beat against the oldest predicted byte. The run starts with one
// directed frame of edge widths, then streams random frames through four
// idling phases. It drains the byte queue between phases.
// ----------------------------------------------------------------------------
module testbench;
  import sbus_enc_pkg::*;

  localparam int unsigned SbSpan     = 1638;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 16;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  servo_pulse_to_sbus_frame_encoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Frame bytes predicted but not yet seen on the output, oldest first
  out_beat_t   pending_bytes[$];

  // Packing state of the scoreboard model
  logic [3:0]  model_chan;
  logic [17:0] model_bits;
  logic [4:0]  model_nbits;

  // Idling knobs, in percent per cycle
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned mismatch_count;
  int unsigned beats_sent;
  int unsigned bytes_checked;
  int unsigned frames_done;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles and kill a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------

  // Clamp the width to 1000..2000 us and scale it onto 173..1811
  function automatic logic [10:0] sbus_value(logic [11:0] width);
    int unsigned w;
    w = width;
    if (w < PwMin) w = PwMin;
    if (w > PwMax) w = PwMax;
    return 11'(SbMin + ((w - PwMin) * SbSpan) / PwSpan);
  endfunction

  function automatic out_beat_t frame_beat(logic [7:0] value, logic last);
    out_beat_t b;
    b.frame_byte = value;
    b.frame_end  = last;
    return b;
  endfunction

  // Advance the model by one accepted channel beat and queue its bytes
  task automatic pack_channel(in_beat_t beat);
    logic [10:0] value;
    value = sbus_value(beat.pulse_width);
    // Open the frame with the header before channel 0
    if (model_chan == 4'd0) pending_bytes.push_back(frame_beat(HdrByte, 1'b0));
    model_bits  = model_bits | (18'(value) << model_nbits[2:0]);
    model_nbits = {2'b00, model_nbits[2:0]} + 5'd11;
    // Emit every byte that has filled
    while (model_nbits >= 5'd8) begin
      pending_bytes.push_back(frame_beat(model_bits[7:0], 1'b0));
      model_bits  = model_bits >> 8;
      model_nbits = model_nbits - 5'd8;
    end
    if (model_chan == ChLast) begin
      // Close the frame: flag from this beat only, then the footer
      pending_bytes.push_back(frame_beat(beat.signal_loss ? FlagLoss : FlagNone, 1'b0));
      pending_bytes.push_back(frame_beat(FtrByte, 1'b1));
      model_bits  = '0;
      model_nbits = '0;
      model_chan  = '0;
      frames_done++;
    end else begin
      model_chan = model_chan + 4'd1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Output checker: stall at random and check each accepted byte
  // --------------------------------------------------------------------------
  initial begin
    out_beat_t want;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected frame beat: frame_byte=%02h frame_end=%0b",
                 out_data_o.frame_byte, out_data_o.frame_end);
          mismatch_count++;
        end else begin
          want = pending_bytes.pop_front();
          bytes_checked++;
          if (out_data_o.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %02h, actual %02h",
                   want.frame_byte, out_data_o.frame_byte);
            mismatch_count++;
          end
          if (out_data_o.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b",
                   want.frame_end, out_data_o.frame_end);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Drive one channel beat, idling first at random, and hold it until taken.
  // Every call starts right after a rising edge.
  task automatic send_channel(logic [11:0] width, logic loss);
    in_beat_t beat;
    beat.pulse_width = width;
    beat.signal_loss = loss;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= in_beat_t'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pack_channel(beat);
    beats_sent++;
  endtask

  // Drop valid and hold off until every predicted byte has been checked
  task automatic drain_frame_bytes();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Mostly in-range widths, some hugging the clamp points, some anywhere
  function automatic logic [11:0] pick_width();
    case ($urandom_range(3))
      0: return 12'($urandom_range(4095));
      1: return $urandom_range(1) ? 12'($urandom_range(1010, 990))
                                  : 12'($urandom_range(2010, 1990));
      default: return 12'($urandom_range(PwMax, PwMin));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One full frame of clamp edges and bit extremes, signal loss set both on
  // an ignored channel and on channel 15
  task automatic test_edge_widths();
    logic [11:0] widths[16];
    widths = '{12'd0, 12'd999, 12'd1000, 12'd1001, 12'd1500, 12'd1999, 12'd2000,
               12'd2001, 12'd4095, 12'd2048, 12'd2047, 12'd1, 12'd1638, 12'd1234,
               12'd1766, 12'd3000};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (widths[i]) send_channel(widths[i], (i == 0) || (i == 15));
    drain_frame_bytes();
  endtask

  // Random frames under one idling setting; the frame after the directed one
  // closes with signal loss clear so a sticky flag shows up
  task automatic test_random_frames(int unsigned count, int unsigned idle_pct,
                                    int unsigned stall_pct);
    logic loss;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      loss = $urandom_range(1);
      if (frames_done == 1 && model_chan == ChLast) loss = 1'b0;
      send_channel(pick_width(), loss);
    end
    drain_frame_bytes();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    model_chan     = '0;
    model_bits     = '0;
    model_nbits    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    beats_sent     = 0;
    bytes_checked  = 0;
    frames_done    = 0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    in_data_i      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_widths();
    test_random_frames(76, 0, 0);
    test_random_frames(72, 72, 0);
    test_random_frames(72, 0, 72);
    test_random_frames(76, 12, 12);

    // Let any stray beat surface before closing
    repeat (TailCycles) @(posedge clk_i);

    $display("summary: %0d channel beats in %0d frames, %0d frame bytes checked,",
             beats_sent, frames_done, bytes_checked);
    $display("summary: clamp edges, flag set and clear, four idling phases");
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
